/* sv/omt_pkg.sv */
`default_nettype none

package omt_pkg;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 5;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  // tdata / tuser widths on the ports
  localparam int IN_DATA_W  = 24;  // lock_id + requester_id, padded to bytes
  localparam int OUT_DATA_W = 8;   // slot_index, padded to a byte

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE  = 2'd0,
    FN_ACQUIRE = 2'd1,
    FN_RELEASE = 2'd2,
    FN_DESTROY = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_INDEX   = 3'd1,
    ST_UNALLOCATED = 3'd2,
    ST_BUSY        = 3'd3,
    ST_NOT_HELD    = 3'd4,
    ST_NOT_OWNER   = 3'd5,
    ST_FULL        = 3'd6
  } status_t;

  // Update applied to one slot of the table
  typedef enum logic [2:0] {
    SOP_NONE  = 3'd0,
    SOP_ALLOC = 3'd1,  // mark allocated, not held, no owner
    SOP_TAKE  = 3'd2,  // mark held by the given owner
    SOP_GIVE  = 3'd3,  // drop the hold, clear the owner
    SOP_FREE  = 3'd4   // clear the whole slot
  } slot_op_t;

  typedef struct packed {
    slot_op_t           op;
    logic [OWNER_W-1:0] owner;
  } slot_cmd_t;

  typedef struct packed {
    logic               allocated;
    logic               held;
    logic [OWNER_W-1:0] owner;
  } slot_view_t;

endpackage

`default_nettype wire

/* sv/owned_mutex_table_unit.sv */
`default_nettype none

// Channel  Dir  Ports                  Word contents
// -------  ---  ---------------------  ------------------------------------------
// in       in   in_tvalid/tready/...   tuser: func; tdata: lock_id, requester_id
// out      out  out_tvalid/tready/...  tuser: status; tdata: slot_index
//
// One request at a time. Acquire, release and destroy pass through S_EXEC
// and then S_DONE from accept to result. Create walks the table one slot per
// cycle in S_SCAN through the single slot read port, lowest index first, and
// stops at the first free slot or at the last one, then passes to S_DONE.
// rst_n (synchronous) clears the whole table; no clearing pass is needed.
// A result waiting on out_tready blocks only the finish of the next request.

module owned_mutex_table_unit
  import omt_pkg::*;
#(
  parameter int LOCK_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [4:0] lock_id, [20:5] requester_id
  input  wire logic [FUNC_W-1:0]     in_tuser,   // [1:0] func

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] slot_index
  output logic [STATUS_W-1:0]        out_tuser   // [2:0] status
);

  localparam int IDX_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_COUNT - 1);
  localparam logic [ID_W:0]    COUNT_EXT = (ID_W + 1)'(LOCK_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DONE
  } state_t;

  state_t               state_r;
  func_t                func_r;
  logic [OWNER_W-1:0]   who_r;
  logic [IDX_W-1:0]     addr_r;      // lock index, or scan position on create
  logic                 in_range_r;
  status_t              status_r;
  logic [SLOT_W-1:0]    slot_r;
  logic                 out_tvalid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  status_t              out_status_r;

  slot_cmd_t            cmd;
  slot_view_t           view;
  logic [ID_W-1:0]      in_lock_id;
  logic [OWNER_W-1:0]   in_requester_id;
  logic                 out_free;

  assign in_lock_id      = in_tdata[ID_W-1:0];
  assign in_requester_id = in_tdata[ID_W+OWNER_W-1:ID_W];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - SLOT_W){1'b0}}, out_slot_r};
  assign out_tuser  = out_status_r;
  assign out_free   = !out_tvalid_r || out_tready;

  omt_slots #(
    .LOCK_COUNT (LOCK_COUNT),
    .IDX_W      (IDX_W)
  ) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (addr_r),
    .cmd   (cmd),
    .view  (view)
  );

  // Slot update: allocate on a free scan hit, otherwise act on the addressed slot
  always_comb begin
    cmd.op    = SOP_NONE;
    cmd.owner = who_r;
    unique case (state_r)
      S_SCAN: begin
        if (!view.allocated) cmd.op = SOP_ALLOC;
      end
      S_EXEC: begin
        if (in_range_r && view.allocated) begin
          unique case (func_r)
            FN_ACQUIRE: if (!view.held) cmd.op = SOP_TAKE;
            FN_RELEASE: if (view.held && view.owner == who_r) cmd.op = SOP_GIVE;
            FN_DESTROY: cmd.op = SOP_FREE;
            FN_CREATE:  cmd.op = SOP_NONE;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop valid once the word is taken, unless S_DONE loads the next one
      if (out_tvalid_r && out_tready && state_r != S_DONE) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            // capture the word; create starts its walk at slot zero
            func_r     <= func_t'(in_tuser);
            who_r      <= in_requester_id;
            in_range_r <= ({1'b0, in_lock_id} < COUNT_EXT);
            if (func_t'(in_tuser) == FN_CREATE) begin
              addr_r  <= '0;
              state_r <= S_SCAN;
            end else begin
              addr_r  <= in_lock_id[IDX_W-1:0];
              state_r <= S_EXEC;
            end
          end
        end

        S_SCAN: begin
          // test one slot per cycle; stop at the first free one or the end
          if (!view.allocated) begin
            status_r <= ST_OK;
            slot_r   <= SLOT_W'(addr_r);
            state_r  <= S_DONE;
          end else if (addr_r == LAST_IDX) begin
            status_r <= ST_FULL;
            slot_r   <= '0;
            state_r  <= S_DONE;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end

        S_EXEC: begin
          slot_r  <= '0;
          state_r <= S_DONE;
          if (!in_range_r) begin
            status_r <= ST_BAD_INDEX;
          end else if (!view.allocated) begin
            status_r <= ST_UNALLOCATED;
          end else begin
            unique case (func_r)
              FN_ACQUIRE: status_r <= view.held ? ST_BUSY : ST_OK;
              FN_RELEASE: begin
                if (!view.held)               status_r <= ST_NOT_HELD;
                else if (view.owner != who_r) status_r <= ST_NOT_OWNER;
                else                          status_r <= ST_OK;
              end
              FN_DESTROY: status_r <= ST_OK;
              FN_CREATE:  status_r <= ST_OK;
            endcase
          end
        end

        S_DONE: begin
          // hold until the output register is free, then hand the word over
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= status_r;
            out_slot_r   <= slot_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/omt_slots.sv */
`default_nettype none

module omt_slots
  import omt_pkg::*;
#(
  parameter int LOCK_COUNT = 16,
  parameter int IDX_W      = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] addr,
  input  wire slot_cmd_t        cmd,
  output slot_view_t            view
);

  logic               alloc_r [LOCK_COUNT];
  logic               held_r  [LOCK_COUNT];
  logic [OWNER_W-1:0] owner_r [LOCK_COUNT];

  // single read port at the shared address
  always_comb begin
    view.allocated = alloc_r[addr];
    view.held      = held_r[addr];
    view.owner     = owner_r[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        alloc_r[i] <= 1'b0;
        held_r[i]  <= 1'b0;
        owner_r[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        SOP_ALLOC: begin
          alloc_r[addr] <= 1'b1;
          held_r[addr]  <= 1'b0;
          owner_r[addr] <= '0;
        end
        SOP_TAKE: begin
          held_r[addr]  <= 1'b1;
          owner_r[addr] <= cmd.owner;
        end
        SOP_GIVE: begin
          held_r[addr]  <= 1'b0;
          owner_r[addr] <= '0;
        end
        SOP_FREE: begin
          alloc_r[addr] <= 1'b0;
          held_r[addr]  <= 1'b0;
          owner_r[addr] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/owned_mutex_table_unit_tb.sv */
`default_nettype none

module owned_mutex_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import omt_pkg::*;

  localparam int SLOTS = 16;

  // Padding above requester_id in the request word
  localparam int IN_PAD_W = IN_DATA_W - ID_W - OWNER_W;

  // What the block should answer for one request
  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } mutex_reply_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;    // [4:0] lock_id, [20:5] requester_id
  logic [FUNC_W-1:0]     in_tuser   = '0;    // [1:0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // [3:0] slot_index
  logic [STATUS_W-1:0]   out_tuser;          // [2:0] status

  // Shadow copy of the lock table, updated when a request word is accepted
  logic               tbl_alloc [SLOTS] = '{default: 1'b0};
  logic               tbl_held  [SLOTS] = '{default: 1'b0};
  logic [OWNER_W-1:0] tbl_owner [SLOTS] = '{default: '0};

  // Replies still owed by the block, oldest first
  mutex_reply_t reply_q[$];

  int unsigned error_count  = 0;
  int unsigned reply_count  = 0;
  bit          idle_on      = 1'b1;  // enable random gaps and stalls on both sides
  int unsigned ready_hold   = 0;     // remaining stall cycles on the result side

  owned_mutex_table_unit #(
    .LOCK_COUNT(SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (long gaps, long stalls,
  // full-table creates on every word)
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, some medium, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small ids collide often enough to hit the owner checks; wide ones
  // toggle every bit of the field
  function automatic logic [OWNER_W-1:0] pick_requester();
    if ($urandom_range(0, 1) == 0) return OWNER_W'($urandom_range(1, 6));
    return OWNER_W'($urandom_range(1, 65535));
  endfunction

  // Random allocated slot of the shadow table, or -1 when none is in use
  function automatic int pick_allocated();
    int live[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_alloc[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Apply one request to the shadow table and return the expected reply
  function automatic mutex_reply_t predict_request(func_t fn, logic [ID_W-1:0] id,
                                                   logic [OWNER_W-1:0] who);
    mutex_reply_t r;
    r.status = ST_OK;
    r.slot   = '0;
    if (fn == FN_CREATE) begin
      // lowest free slot wins; it starts unlocked with no owner
      r.status = ST_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!tbl_alloc[i]) begin
          tbl_alloc[i] = 1'b1;
          tbl_held[i]  = 1'b0;
          tbl_owner[i] = '0;
          r.status     = ST_OK;
          r.slot       = SLOT_W'(i);
          break;
        end
      end
    end else if (id >= SLOTS) begin
      r.status = ST_BAD_INDEX;
    end else if (!tbl_alloc[id]) begin
      r.status = ST_UNALLOCATED;
    end else if (fn == FN_ACQUIRE) begin
      // a held slot answers busy, even to its own owner
      if (tbl_held[id]) begin
        r.status = ST_BUSY;
      end else begin
        tbl_held[id]  = 1'b1;
        tbl_owner[id] = who;
      end
    end else if (fn == FN_RELEASE) begin
      if (!tbl_held[id]) begin
        r.status = ST_NOT_HELD;
      end else if (tbl_owner[id] != who) begin
        r.status = ST_NOT_OWNER;
      end else begin
        tbl_held[id]  = 1'b0;
        tbl_owner[id] = '0;
      end
    end else begin
      // destroy frees the slot whether or not it is locked
      tbl_alloc[id] = 1'b0;
      tbl_held[id]  = 1'b0;
      tbl_owner[id] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns reply %0d: %s", $time, reply_count, msg);
    error_count++;
  endtask

  // Present one request word, hold it until accepted, then record the reply
  // it must produce. Call at a rising edge.
  task automatic send_request(func_t fn, logic [ID_W-1:0] id, logic [OWNER_W-1:0] who);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      // drop valid and scribble on the idle bus
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'($urandom());
      in_tuser  <= FUNC_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {{IN_PAD_W{1'b0}}, who, id};
    do @(posedge clk); while (!in_tready);
    reply_q.push_back(predict_request(fn, id, who));
  endtask

  // Drop valid and hold off until every owed reply has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  // Result side: stall at random, in runs
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest owed reply
  always @(posedge clk) begin
    mutex_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d slot=%0d",
                                  out_tuser, out_tdata[SLOT_W-1:0]));
      end else begin
        want = reply_q.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %s", out_tuser, want.status.name()));
        if (out_tdata[SLOT_W-1:0] !== want.slot)
          report_mismatch($sformatf("slot_index %0d, want %0d",
                                    out_tdata[SLOT_W-1:0], want.slot));
      end
      reply_count++;
    end
  end

  // Out-of-range indexes (bit 4 of lock_id set) and a slot never created
  task automatic test_bad_index();
    send_request(FN_ACQUIRE, 5'd16, 16'h0001);
    send_request(FN_DESTROY, 5'd31, 16'hFFFF);
    send_request(FN_RELEASE, 5'd0,  16'h0001);
    drain_results();
  endtask

  // Fill every slot in order, then one create past the end
  task automatic test_table_full();
    for (int i = 0; i <= SLOTS; i++) send_request(FN_CREATE, ID_W'(i), 16'h0001);
    drain_results();
  endtask

  // Busy, owner re-acquire, wrong owner, not held, requester zero,
  // destroy while locked, and reuse of the lowest free slot
  task automatic test_lock_rules();
    send_request(FN_ACQUIRE, 5'd0,  16'hFFFF);
    send_request(FN_ACQUIRE, 5'd0,  16'hFFFF);
    send_request(FN_RELEASE, 5'd0,  16'h0001);
    send_request(FN_RELEASE, 5'd0,  16'hFFFF);
    send_request(FN_RELEASE, 5'd0,  16'hFFFF);
    send_request(FN_ACQUIRE, 5'd15, 16'h0000);
    send_request(FN_DESTROY, 5'd15, 16'h5A5A);
    send_request(FN_ACQUIRE, 5'd15, 16'h0001);
    send_request(FN_CREATE,  5'd3,  16'h0001);
    drain_results();
  endtask

  // Mostly well-formed lock traffic on live slots, with some raw noise
  task automatic test_random(int unsigned count);
    int          slot;
    int unsigned roll;
    for (int unsigned n = 0; n < count; n++) begin
      // the stretch from n == 100 always runs with no gaps or stalls; others may at random
      if (n % 100 == 0) idle_on = (n == 100) ? 1'b0 : ($urandom_range(0, 3) != 0);
      // pause once mid-run until the block has answered everything
      if (n == count / 2) drain_results();
      roll = $urandom_range(0, 99);
      slot = pick_allocated();
      if (roll < 18 || (roll < 80 && slot < 0)) begin
        send_request(FN_CREATE, ID_W'($urandom_range(0, 31)), pick_requester());
      end else if (roll < 70) begin
        if (tbl_held[slot]) begin
          // mostly the owner lets go; otherwise a rival pokes at the lock
          if ($urandom_range(0, 3) != 0)
            send_request(FN_RELEASE, ID_W'(slot), tbl_owner[slot]);
          else if ($urandom_range(0, 1) == 0)
            send_request(FN_RELEASE, ID_W'(slot), pick_requester());
          else
            send_request(FN_ACQUIRE, ID_W'(slot), pick_requester());
        end else begin
          if ($urandom_range(0, 4) != 0)
            send_request(FN_ACQUIRE, ID_W'(slot), pick_requester());
          else
            send_request(FN_RELEASE, ID_W'(slot), pick_requester());
        end
      end else if (roll < 80) begin
        send_request(FN_DESTROY, ID_W'(slot), pick_requester());
      end else begin
        send_request(func_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 31)),
                     OWNER_W'($urandom_range(0, 65535)));
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_index();
    test_table_full();
    test_lock_rules();
    test_random(770);

    // Let the last replies come in, with a bound, then a short quiet spell
    in_tvalid <= 1'b0;
    for (int c = 0; c < 2000 && reply_q.size() != 0; c++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (reply_q.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", reply_q.size()));

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
